// ===== rtl/core/ps2tx_pkg.sv =====
// shared types, phase codes and register indexes for the ps2 host byte transmitter
`timescale 1ns / 1ps

package ps2tx_pkg;

    // payload layout
    localparam int DataBits     = 8;
    localparam int CountWidth   = 14;
    localparam int ErrWidth     = 4;
    localparam int PhaseWidth   = 4;
    localparam int BitIdxWidth  = 3;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 14;
    localparam int InDataWidth  = 16;
    localparam int OutDataWidth = 8;

    // register indexes on the configuration port
    localparam logic [CfgIdxWidth-1:0] REG_INHIBIT_TIME    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_SETUP_DELAY     = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_REQUEST_TIMEOUT = 2'd2;
    localparam logic [CfgIdxWidth-1:0] REG_EDGE_TIMEOUT    = 2'd3;

    // register reset values
    localparam logic [9:0]  INHIBIT_TIME_RST    = 10'd100;
    localparam logic [7:0]  SETUP_DELAY_RST     = 8'd15;
    localparam logic [13:0] REQUEST_TIMEOUT_RST = 14'd10000;
    localparam logic [9:0]  EDGE_TIMEOUT_RST    = 10'd50;

    // send sequence phases
    localparam logic [PhaseWidth-1:0] PH_IDLE       = 4'd0;
    localparam logic [PhaseWidth-1:0] PH_INHIBIT    = 4'd1;
    localparam logic [PhaseWidth-1:0] PH_REQ        = 4'd2;
    localparam logic [PhaseWidth-1:0] PH_BIT_SETUP  = 4'd3;
    localparam logic [PhaseWidth-1:0] PH_BIT_HI     = 4'd4;
    localparam logic [PhaseWidth-1:0] PH_BIT_LO     = 4'd5;
    localparam logic [PhaseWidth-1:0] PH_PAR_SETUP  = 4'd6;
    localparam logic [PhaseWidth-1:0] PH_PAR_HI     = 4'd7;
    localparam logic [PhaseWidth-1:0] PH_PAR_LO     = 4'd8;
    localparam logic [PhaseWidth-1:0] PH_STOP_SETUP = 4'd9;
    localparam logic [PhaseWidth-1:0] PH_ACK_DATA   = 4'd10;
    localparam logic [PhaseWidth-1:0] PH_ACK_CLK    = 4'd11;
    localparam logic [PhaseWidth-1:0] PH_IDLE_CLK   = 4'd12;
    localparam logic [PhaseWidth-1:0] PH_IDLE_DATA  = 4'd13;

    // error codes
    localparam logic [ErrWidth-1:0] ERR_OK           = 4'd0;
    localparam logic [ErrWidth-1:0] ERR_REQUEST      = 4'd1;
    localparam logic [ErrWidth-1:0] ERR_BIT_CLK_HI   = 4'd2;
    localparam logic [ErrWidth-1:0] ERR_BIT_CLK_LO   = 4'd3;
    localparam logic [ErrWidth-1:0] ERR_PAR_CLK_HI   = 4'd4;
    localparam logic [ErrWidth-1:0] ERR_PAR_CLK_LO   = 4'd5;
    localparam logic [ErrWidth-1:0] ERR_ACK_DATA     = 4'd6;
    localparam logic [ErrWidth-1:0] ERR_ACK_CLK      = 4'd7;
    localparam logic [ErrWidth-1:0] ERR_IDLE_CLK     = 4'd8;
    localparam logic [ErrWidth-1:0] ERR_IDLE_DATA    = 4'd9;

    // transmitter state carried from tick to tick
    typedef struct packed {
        logic [PhaseWidth-1:0]  phase;
        logic [BitIdxWidth-1:0] bit_index;
        logic [DataBits-1:0]    shift_byte;
        logic                   odd_parity;
        logic [CountWidth-1:0]  tick_count;
        logic [ErrWidth-1:0]    last_error;
        logic                   clk_drive;
        logic                   dat_drive;
    } ps2tx_state_t;

    // timing registers
    typedef struct packed {
        logic [9:0]  inhibit_time;
        logic [7:0]  setup_delay;
        logic [13:0] request_timeout;
        logic [9:0]  edge_timeout;
    } ps2tx_cfg_t;

    // sampled line levels and start request of one tick
    typedef struct packed {
        logic                start_send;
        logic [DataBits-1:0] tx_byte;
        logic                clk_hi;
        logic                dat_hi;
    } ps2tx_tick_t;

endpackage

// ===== rtl/core/ps2_host_byte_transmitter_unit.sv =====
// top level of the ps2 host-to-device byte transmitter
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata: one microsecond tick of line samples
//  m_        out        m_tvalid/m_tready    m_tdata: line drives, busy, error; m_tlast: send end
//  cfg_      in         cfg_wr_en            cfg_wr_index, cfg_wr_data: timing registers
//
// the state update for a tick sits between the
// state registers and the result register, so a tick can be taken every cycle
// while m_tready is high; the result appears in the cycle after its request.
// a stalled result holds in the output register and s_tready drops until it is taken.
// aresetn is synchronous and active low; it returns the sequence to idle and
// restores the timing registers to their defaults.
`timescale 1ns / 1ps

module ps2_host_byte_transmitter_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // start_send [0], tx_byte [8:1], clock_line [9], data_line [10], zero [15:11]
    input  logic [ps2tx_pkg::InDataWidth-1:0]     s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // clock_pull_low [0], data_pull_low [1], busy_res [2], error_code [6:3], zero [7]
    output logic [ps2tx_pkg::OutDataWidth-1:0]    m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [ps2tx_pkg::CfgIdxWidth-1:0]     cfg_wr_index,
    input  logic [ps2tx_pkg::CfgDataWidth-1:0]    cfg_wr_data
);

    ps2tx_pkg::ps2tx_state_t               state_reg;
    ps2tx_pkg::ps2tx_state_t               state_next;
    ps2tx_pkg::ps2tx_cfg_t                 cfg_reg;
    ps2tx_pkg::ps2tx_tick_t                tick;
    logic                                  done_next;
    logic                                  s_accept;
    logic [ps2tx_pkg::OutDataWidth-1:0]    m_tdata_reg;
    logic [ps2tx_pkg::OutDataWidth-1:0]    m_tdata_next;
    logic                                  m_tlast_reg;
    logic                                  m_tvalid_reg;

    // unpack the incoming tick
    assign tick.start_send = s_tdata[0];
    assign tick.tx_byte    = s_tdata[8:1];
    assign tick.clk_hi     = s_tdata[9];
    assign tick.dat_hi     = s_tdata[10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inhibit_time    <= ps2tx_pkg::INHIBIT_TIME_RST;
            cfg_reg.setup_delay     <= ps2tx_pkg::SETUP_DELAY_RST;
            cfg_reg.request_timeout <= ps2tx_pkg::REQUEST_TIMEOUT_RST;
            cfg_reg.edge_timeout    <= ps2tx_pkg::EDGE_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ps2tx_pkg::REG_INHIBIT_TIME:    cfg_reg.inhibit_time    <= cfg_wr_data[9:0];
                ps2tx_pkg::REG_SETUP_DELAY:     cfg_reg.setup_delay     <= cfg_wr_data[7:0];
                ps2tx_pkg::REG_REQUEST_TIMEOUT: cfg_reg.request_timeout <= cfg_wr_data;
                ps2tx_pkg::REG_EDGE_TIMEOUT:    cfg_reg.edge_timeout    <= cfg_wr_data[9:0];
                default: ;
            endcase
        end
    end

    ps2tx_step u_step (
        .state_i (state_reg),
        .cfg_i   (cfg_reg),
        .tick_i  (tick),
        .state_o (state_next),
        .done_o  (done_next)
    );

    // result built from the state after this tick
    assign m_tdata_next = {1'b0,
                           state_next.last_error,
                           (state_next.phase != ps2tx_pkg::PH_IDLE),
                           state_next.dat_drive,
                           state_next.clk_drive};

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= ps2tx_pkg::PH_IDLE;
            state_reg.bit_index  <= '0;
            state_reg.shift_byte <= '0;
            state_reg.odd_parity <= 1'b1;
            state_reg.tick_count <= '0;
            state_reg.last_error <= ps2tx_pkg::ERR_OK;
            state_reg.clk_drive  <= 1'b0;
            state_reg.dat_drive  <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/core/ps2tx_step.sv =====
// next-state logic of the send sequence for one microsecond tick
`timescale 1ns / 1ps

module ps2tx_step (
    input  ps2tx_pkg::ps2tx_state_t state_i,
    input  ps2tx_pkg::ps2tx_cfg_t   cfg_i,
    input  ps2tx_pkg::ps2tx_tick_t  tick_i,
    output ps2tx_pkg::ps2tx_state_t state_o,
    output logic                    done_o
);

    // abort or finish: release both lines and go idle
    function automatic ps2tx_pkg::ps2tx_state_t end_send(
        input ps2tx_pkg::ps2tx_state_t st,
        input logic [ps2tx_pkg::ErrWidth-1:0] code
    );
        ps2tx_pkg::ps2tx_state_t r;
        r            = st;
        r.clk_drive  = 1'b0;
        r.dat_drive  = 1'b0;
        r.phase      = ps2tx_pkg::PH_IDLE;
        r.tick_count = '0;
        r.last_error = code;
        return r;
    endfunction

    // one tick of a line wait with timeout
    function automatic ps2tx_pkg::ps2tx_state_t line_wait(
        input ps2tx_pkg::ps2tx_state_t st,
        input logic ok,
        input logic [ps2tx_pkg::CountWidth-1:0] limit,
        input logic [ps2tx_pkg::PhaseWidth-1:0] nxt,
        input logic [ps2tx_pkg::ErrWidth-1:0] code
    );
        ps2tx_pkg::ps2tx_state_t r;
        logic [ps2tx_pkg::CountWidth-1:0] cnt;
        r   = st;
        cnt = st.tick_count + 1'b1;
        if (ok) begin
            r.phase      = nxt;
            r.tick_count = '0;
        end else if (cnt >= limit) begin
            r = end_send(st, code);
        end else begin
            r.tick_count = cnt;
        end
        return r;
    endfunction

    logic [ps2tx_pkg::CountWidth-1:0] edge_limit;
    logic [ps2tx_pkg::CountWidth-1:0] setup_limit;
    logic [ps2tx_pkg::CountWidth-1:0] inhibit_limit;
    logic [ps2tx_pkg::CountWidth-1:0] cnt_inc;
    logic                             setup_done;
    logic                             cur_bit;

    assign edge_limit    = {4'd0, cfg_i.edge_timeout};
    assign setup_limit   = {6'd0, cfg_i.setup_delay};
    assign inhibit_limit = {4'd0, cfg_i.inhibit_time};
    assign cnt_inc       = state_i.tick_count + 1'b1;
    assign setup_done    = (state_i.tick_count >= setup_limit);
    assign cur_bit       = state_i.shift_byte[state_i.bit_index];

    // phase sequencing
    always_comb begin
        state_o = state_i;
        case (state_i.phase)
            ps2tx_pkg::PH_IDLE: begin
                if (tick_i.start_send) begin
                    state_o.shift_byte = tick_i.tx_byte;
                    state_o.bit_index  = '0;
                    state_o.odd_parity = 1'b1;
                    state_o.tick_count = '0;
                    state_o.last_error = ps2tx_pkg::ERR_OK;
                    state_o.clk_drive  = 1'b1;
                    state_o.dat_drive  = 1'b0;
                    state_o.phase      = ps2tx_pkg::PH_INHIBIT;
                end
            end
            ps2tx_pkg::PH_INHIBIT: begin
                if (cnt_inc >= inhibit_limit) begin
                    state_o.clk_drive  = 1'b0;
                    state_o.dat_drive  = 1'b1;
                    state_o.tick_count = '0;
                    state_o.phase      = ps2tx_pkg::PH_REQ;
                end else begin
                    state_o.tick_count = cnt_inc;
                end
            end
            ps2tx_pkg::PH_REQ: begin
                state_o = line_wait(state_i, !tick_i.clk_hi, cfg_i.request_timeout,
                                    ps2tx_pkg::PH_BIT_SETUP, ps2tx_pkg::ERR_REQUEST);
            end
            ps2tx_pkg::PH_BIT_SETUP: begin
                if (setup_done) begin
                    state_o.tick_count = '0;
                    state_o.odd_parity = state_i.odd_parity ^ cur_bit;
                    state_o.dat_drive  = ~cur_bit;
                    state_o.phase      = ps2tx_pkg::PH_BIT_HI;
                end else begin
                    state_o.tick_count = cnt_inc;
                end
            end
            ps2tx_pkg::PH_BIT_HI: begin
                state_o = line_wait(state_i, tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_BIT_LO, ps2tx_pkg::ERR_BIT_CLK_HI);
            end
            ps2tx_pkg::PH_BIT_LO: begin
                state_o = line_wait(state_i, !tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_BIT_SETUP, ps2tx_pkg::ERR_BIT_CLK_LO);
                // after the falling edge move to the next bit or to parity
                if (!tick_i.clk_hi) begin
                    if (state_i.bit_index == ps2tx_pkg::BitIdxWidth'(ps2tx_pkg::DataBits - 1))
                    begin
                        state_o.bit_index = '0;
                        state_o.phase     = ps2tx_pkg::PH_PAR_SETUP;
                    end else begin
                        state_o.bit_index = state_i.bit_index + 1'b1;
                    end
                end
            end
            ps2tx_pkg::PH_PAR_SETUP: begin
                if (setup_done) begin
                    state_o.tick_count = '0;
                    state_o.dat_drive  = ~state_i.odd_parity;
                    state_o.phase      = ps2tx_pkg::PH_PAR_HI;
                end else begin
                    state_o.tick_count = cnt_inc;
                end
            end
            ps2tx_pkg::PH_PAR_HI: begin
                state_o = line_wait(state_i, tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_PAR_LO, ps2tx_pkg::ERR_PAR_CLK_HI);
            end
            ps2tx_pkg::PH_PAR_LO: begin
                state_o = line_wait(state_i, !tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_STOP_SETUP, ps2tx_pkg::ERR_PAR_CLK_LO);
            end
            ps2tx_pkg::PH_STOP_SETUP: begin
                if (setup_done) begin
                    state_o.tick_count = '0;
                    state_o.dat_drive  = 1'b0;
                    state_o.phase      = ps2tx_pkg::PH_ACK_DATA;
                end else begin
                    state_o.tick_count = cnt_inc;
                end
            end
            ps2tx_pkg::PH_ACK_DATA: begin
                state_o = line_wait(state_i, !tick_i.dat_hi, edge_limit,
                                    ps2tx_pkg::PH_ACK_CLK, ps2tx_pkg::ERR_ACK_DATA);
            end
            ps2tx_pkg::PH_ACK_CLK: begin
                state_o = line_wait(state_i, !tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_IDLE_CLK, ps2tx_pkg::ERR_ACK_CLK);
            end
            ps2tx_pkg::PH_IDLE_CLK: begin
                state_o = line_wait(state_i, tick_i.clk_hi, edge_limit,
                                    ps2tx_pkg::PH_IDLE_DATA, ps2tx_pkg::ERR_IDLE_CLK);
            end
            ps2tx_pkg::PH_IDLE_DATA: begin
                // data back high completes the send with no error
                if (tick_i.dat_hi) begin
                    state_o = end_send(state_i, ps2tx_pkg::ERR_OK);
                end else begin
                    state_o = line_wait(state_i, 1'b0, edge_limit,
                                        ps2tx_pkg::PH_IDLE, ps2tx_pkg::ERR_IDLE_DATA);
                end
            end
            default: begin
                state_o = end_send(state_i, ps2tx_pkg::ERR_OK);
            end
        endcase
    end

    // a send ends exactly when a busy phase returns to idle
    assign done_o = (state_i.phase != ps2tx_pkg::PH_IDLE) &&
                    (state_o.phase == ps2tx_pkg::PH_IDLE);

endmodule
